@@ rtl/core/hqs_pkg.sv @@
// ----------------------------------------------------------------------------
// hqs_pkg
// Shared types and constants for the quicksort engine: channel payloads,
// compare flags and the sequencer state encoding.
// ----------------------------------------------------------------------------
package hqs_pkg;

   localparam int VALUE_W = 32;

   // input transaction
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   // result transaction
   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      last_out;
      logic                      overflow;
   } rsp_type;

   // flags from the shared comparator
   typedef struct packed {
      logic lt;
      logic gt;
   } cmp_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RANGE,
      ST_PIVOT,
      ST_SCAN_I,
      ST_SCAN_J,
      ST_SWAP,
      ST_SWAP_RD,
      ST_SPLIT,
      ST_INS_K,
      ST_INS_V,
      ST_INS_M,
      ST_INS_CMP,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

endpackage

@@ rtl/core/hqs_value_mem.sv @@
// ----------------------------------------------------------------------------
// hqs_value_mem
// Value store: one write port and one read port with registered read data.
// Read data holds when no read is issued.
// ----------------------------------------------------------------------------
module hqs_value_mem #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic signed [hqs_pkg::VALUE_W-1:0]  wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic signed [hqs_pkg::VALUE_W-1:0]  rd_data
);

   logic signed [hqs_pkg::VALUE_W-1:0] mem [DEPTH];
   logic signed [hqs_pkg::VALUE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/hqs_compare.sv @@
// ----------------------------------------------------------------------------
// hqs_compare
// Shared signed comparator: memory read data against the held key
// (pivot during partition, moving value during insertion).
// ----------------------------------------------------------------------------
module hqs_compare (
   input  logic signed [hqs_pkg::VALUE_W-1:0] a,
   input  logic signed [hqs_pkg::VALUE_W-1:0] b,
   output hqs_pkg::cmp_type                   result
);

   always_comb begin
      result.lt = (a < b);
      result.gt = (a > b);
   end

endmodule

@@ rtl/core/hqs_ctrl.sv @@
// ----------------------------------------------------------------------------
// hqs_ctrl
// Sequencer: loads values, runs Hoare partitioning with a middle pivot over
// an explicit range stack (insertion sort when the stack is full), then
// reads the store out in order.
// ----------------------------------------------------------------------------
module hqs_ctrl #(
   parameter int DEPTH       = 64,
   parameter int STACK_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   input  hqs_pkg::req_type                    req_payload,
   output logic                                req_stall,
   // result register hookup
   input  logic                                out_free,
   output logic                                out_load,
   output hqs_pkg::rsp_type                    out_item,
   // value store
   output logic                                mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]            mem_wr_addr,
   output logic signed [hqs_pkg::VALUE_W-1:0]  mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]            mem_rd_addr,
   input  logic signed [hqs_pkg::VALUE_W-1:0]  mem_rd_data,
   // shared comparator
   output logic signed [hqs_pkg::VALUE_W-1:0]  cmp_key,
   input  hqs_pkg::cmp_type                    cmp_result
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int SPI_W = $clog2(STACK_DEPTH);

   hqs_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]                    count_ff, count_in;
   logic                                ovf_ff, ovf_in;
   logic [IDX_W-1:0]                    lo_ff, lo_in;
   logic [IDX_W-1:0]                    hi_ff, hi_in;
   logic [IDX_W-1:0]                    i_ff, i_in;
   logic [IDX_W-1:0]                    j_ff, j_in;
   logic [IDX_W-1:0]                    blo_ff, blo_in;
   logic [IDX_W-1:0]                    bhi_ff, bhi_in;
   logic [CNT_W-1:0]                    k_ff, k_in;
   logic signed [hqs_pkg::VALUE_W-1:0]  key_ff, key_in;
   logic signed [hqs_pkg::VALUE_W-1:0]  vi_ff, vi_in;
   logic [SP_W-1:0]                     sp_ff, sp_in;
   logic [2*IDX_W-1:0]                  stack_ff [STACK_DEPTH];

   logic                                push_en;
   logic [2*IDX_W-1:0]                  push_entry;

   // decoded helpers
   logic                                accept;
   logic                                room;
   logic [CNT_W-1:0]                    count_next_load;
   logic [IDX_W:0]                      mid_sum;
   logic [IDX_W:0]                      left_size;
   logic [IDX_W:0]                      right_size;
   logic                                left_small;
   logic                                stack_full;
   logic [SP_W-1:0]                     sp_m1;
   logic [2*IDX_W-1:0]                  top_entry;
   logic                                out_is_last;

   assign accept          = req_valid && !req_stall;
   assign room            = (count_ff < CNT_W'(DEPTH));
   assign count_next_load = room ? (count_ff + CNT_W'(1)) : count_ff;
   assign mid_sum         = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign left_size       = {1'b0, j_ff} - {1'b0, lo_ff} + (IDX_W+1)'(1);
   assign right_size      = {1'b0, hi_ff} - {1'b0, j_ff};
   assign left_small      = (left_size <= right_size);
   assign stack_full      = (sp_ff == SP_W'(STACK_DEPTH));
   assign sp_m1           = sp_ff - SP_W'(1);
   assign top_entry       = stack_ff[sp_m1[SPI_W-1:0]];
   assign out_is_last     = (k_ff == (count_ff - CNT_W'(1)));
   assign req_stall       = (state_ff != hqs_pkg::ST_LOAD);
   assign cmp_key         = key_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hqs_pkg::ST_LOAD: begin
            if (accept && req_payload.last) begin
               state_in = hqs_pkg::ST_RANGE;
            end
         end
         hqs_pkg::ST_RANGE: begin
            if (lo_ff < hi_ff) begin
               state_in = hqs_pkg::ST_PIVOT;
            end else if (sp_ff == '0) begin
               state_in = hqs_pkg::ST_OUT_RD;
            end
         end
         hqs_pkg::ST_PIVOT:   state_in = hqs_pkg::ST_SCAN_I;
         hqs_pkg::ST_SCAN_I: begin
            if (!((i_ff < hi_ff) && cmp_result.lt)) begin
               state_in = hqs_pkg::ST_SCAN_J;
            end
         end
         hqs_pkg::ST_SCAN_J: begin
            if (!((j_ff > lo_ff) && cmp_result.gt)) begin
               state_in = (i_ff >= j_ff) ? hqs_pkg::ST_SPLIT : hqs_pkg::ST_SWAP;
            end
         end
         hqs_pkg::ST_SWAP:    state_in = hqs_pkg::ST_SWAP_RD;
         hqs_pkg::ST_SWAP_RD: state_in = hqs_pkg::ST_SCAN_I;
         hqs_pkg::ST_SPLIT: begin
            state_in = stack_full ? hqs_pkg::ST_INS_K : hqs_pkg::ST_RANGE;
         end
         hqs_pkg::ST_INS_K: begin
            state_in = (k_ff > {1'b0, bhi_ff}) ? hqs_pkg::ST_RANGE : hqs_pkg::ST_INS_V;
         end
         hqs_pkg::ST_INS_V:   state_in = hqs_pkg::ST_INS_M;
         hqs_pkg::ST_INS_M: begin
            state_in = (i_ff > blo_ff) ? hqs_pkg::ST_INS_CMP : hqs_pkg::ST_INS_K;
         end
         hqs_pkg::ST_INS_CMP: begin
            state_in = cmp_result.gt ? hqs_pkg::ST_INS_M : hqs_pkg::ST_INS_K;
         end
         hqs_pkg::ST_OUT_RD:  state_in = hqs_pkg::ST_OUT_LD;
         hqs_pkg::ST_OUT_LD: begin
            if (out_free) begin
               state_in = out_is_last ? hqs_pkg::ST_LOAD : hqs_pkg::ST_OUT_RD;
            end
         end
         default:             state_in = hqs_pkg::ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      blo_in      = blo_ff;
      bhi_in      = bhi_ff;
      k_in        = k_ff;
      key_in      = key_ff;
      vi_in       = vi_ff;
      sp_in       = sp_ff;
      push_en     = 1'b0;
      push_entry  = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      out_load    = 1'b0;
      out_item.sorted_value = mem_rd_data;
      out_item.last_out     = out_is_last;
      out_item.overflow     = ovf_ff;

      unique case (state_ff)
         // collect values; a full store drops and flags
         hqs_pkg::ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = count_ff[IDX_W-1:0];
                  mem_wr_data = req_payload.value;
               end else begin
                  ovf_in = 1'b1;
               end
               count_in = count_next_load;
               if (req_payload.last) begin
                  lo_in = '0;
                  hi_in = IDX_W'(count_next_load - CNT_W'(1));
                  sp_in = '0;
               end
            end
         end
         // pick next range: partition, pop, or finish
         hqs_pkg::ST_RANGE: begin
            if (lo_ff < hi_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid_sum[IDX_W:1];
            end else if (sp_ff == '0) begin
               k_in = '0;
            end else begin
               sp_in = sp_m1;
               lo_in = top_entry[2*IDX_W-1:IDX_W];
               hi_in = top_entry[IDX_W-1:0];
            end
         end
         hqs_pkg::ST_PIVOT: begin
            key_in      = mem_rd_data;
            i_in        = lo_ff;
            j_in        = hi_ff;
            mem_rd_en   = 1'b1;
            mem_rd_addr = lo_ff;
         end
         // scan up from the left while below pivot
         hqs_pkg::ST_SCAN_I: begin
            mem_rd_en = 1'b1;
            if ((i_ff < hi_ff) && cmp_result.lt) begin
               i_in        = i_ff + IDX_W'(1);
               mem_rd_addr = i_ff + IDX_W'(1);
            end else begin
               vi_in       = mem_rd_data;
               mem_rd_addr = j_ff;
            end
         end
         // scan down from the right while above pivot
         hqs_pkg::ST_SCAN_J: begin
            if ((j_ff > lo_ff) && cmp_result.gt) begin
               j_in        = j_ff - IDX_W'(1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = j_ff - IDX_W'(1);
            end else if (i_ff < j_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = i_ff;
               mem_wr_data = mem_rd_data;
            end
         end
         hqs_pkg::ST_SWAP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = j_ff;
            mem_wr_data = vi_ff;
            i_in        = i_ff + IDX_W'(1);
            j_in        = j_ff - IDX_W'(1);
         end
         hqs_pkg::ST_SWAP_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = i_ff;
         end
         // keep the smaller side, push or insertion-sort the larger
         hqs_pkg::ST_SPLIT: begin
            if (left_small) begin
               blo_in = j_ff + IDX_W'(1);
               bhi_in = hi_ff;
               hi_in  = j_ff;
               push_entry = {j_ff + IDX_W'(1), hi_ff};
            end else begin
               blo_in = lo_ff;
               bhi_in = j_ff;
               lo_in  = j_ff + IDX_W'(1);
               push_entry = {lo_ff, j_ff};
            end
            if (stack_full) begin
               k_in = left_small ? (CNT_W'(j_ff) + CNT_W'(2)) : (CNT_W'(lo_ff) + CNT_W'(1));
            end else begin
               push_en = 1'b1;
               sp_in   = sp_ff + SP_W'(1);
            end
         end
         // insertion sort of [blo, bhi]
         hqs_pkg::ST_INS_K: begin
            if (k_ff <= {1'b0, bhi_ff}) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = k_ff[IDX_W-1:0];
            end
         end
         hqs_pkg::ST_INS_V: begin
            key_in = mem_rd_data;
            i_in   = k_ff[IDX_W-1:0];
         end
         hqs_pkg::ST_INS_M: begin
            if (i_ff > blo_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = i_ff - IDX_W'(1);
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = i_ff;
               mem_wr_data = key_ff;
               k_in        = k_ff + CNT_W'(1);
            end
         end
         hqs_pkg::ST_INS_CMP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = i_ff;
            if (cmp_result.gt) begin
               mem_wr_data = mem_rd_data;
               i_in        = i_ff - IDX_W'(1);
            end else begin
               mem_wr_data = key_ff;
               k_in        = k_ff + CNT_W'(1);
            end
         end
         // read out in order
         hqs_pkg::ST_OUT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = k_ff[IDX_W-1:0];
         end
         hqs_pkg::ST_OUT_LD: begin
            if (out_free) begin
               out_load = 1'b1;
               if (out_is_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  sp_in    = '0;
               end else begin
                  k_in = k_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hqs_pkg::ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         sp_ff    <= sp_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      blo_ff <= blo_in;
      bhi_ff <= bhi_in;
      k_ff   <= k_in;
      key_ff <= key_in;
      vi_ff  <= vi_in;
   end

   // range stack
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_ff[sp_ff[SPI_W-1:0]] <= push_entry;
      end
   end

   // checks
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("range stack pointer past its depth");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count past store depth");

   a_scan_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hqs_pkg::ST_SCAN_I || state_ff == hqs_pkg::ST_SCAN_J) |->
         (lo_ff < hi_ff) && (i_ff >= lo_ff) && (i_ff <= hi_ff) &&
         (j_ff >= lo_ff) && (j_ff <= hi_ff))
      else $error("partition scan index outside its range");

   a_last_starts_sort: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.last) |=> (state_ff == hqs_pkg::ST_RANGE) && (count_ff != '0))
      else $error("last transaction did not start the sort");

   a_final_result_clears: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_item.last_out) |=>
         (state_ff == hqs_pkg::ST_LOAD) && (count_ff == '0) && !ovf_ff)
      else $error("list state not cleared after the final result");

endmodule

@@ rtl/core/hoare_quicksort_engine.sv @@
// Input: one value accepted per cycle while loading; the input stalls from the
// last transaction until the final result is loaded. The sort works in place,
// with one store access at a time plus range bookkeeping, and falls back to
// insertion sort where the range stack is full.
// Output: each result is read from the single read port after the last is loaded.
// Reset: synchronous; clears the sequencer, counts, overflow flag and result valid.
// ----------------------------------------------------------------------------
// hoare_quicksort_engine
// Collects signed values until a last transaction, sorts them in place with
// Hoare partitioning around a middle pivot, then streams them out ascending.
// ----------------------------------------------------------------------------
module hoare_quicksort_engine #(
   parameter int DEPTH       = 64,
   parameter int STACK_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   // input channel
   input  logic              req_valid,
   output logic              req_stall,
   input  hqs_pkg::req_type  req_payload,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hqs_pkg::rsp_type  rsp_payload
);

   localparam int IDX_W = $clog2(DEPTH);

   logic                                mem_wr_en;
   logic [IDX_W-1:0]                    mem_wr_addr;
   logic signed [hqs_pkg::VALUE_W-1:0]  mem_wr_data;
   logic                                mem_rd_en;
   logic [IDX_W-1:0]                    mem_rd_addr;
   logic signed [hqs_pkg::VALUE_W-1:0]  mem_rd_data;
   logic signed [hqs_pkg::VALUE_W-1:0]  cmp_key;
   hqs_pkg::cmp_type                    cmp_result;

   logic                                out_free;
   logic                                out_load;
   hqs_pkg::rsp_type                    out_item;

   logic                                rsp_valid_ff, rsp_valid_in;
   hqs_pkg::rsp_type                    rsp_payload_ff;

   hqs_ctrl #(
      .DEPTH       (DEPTH),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_item    (out_item),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .cmp_key     (cmp_key),
      .cmp_result  (cmp_result)
   );

   hqs_value_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   hqs_compare u_cmp (
      .a      (mem_rd_data),
      .b      (cmp_key),
      .result (cmp_result)
   );

   // result register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_payload_ff <= out_item;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
